FILE: src/usb_ep0_control_transfer_unit_macros.svh
// Assertion macros for the endpoint zero control transfer unit.
// Included by files that carry concurrent checks; uses i_clk and i_rst_n of the includer.
`ifndef USB_EP0_CONTROL_TRANSFER_UNIT_MACROS_SVH
`define USB_EP0_CONTROL_TRANSFER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EP0_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EP0_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ep0ctu_pkg.sv
// Shared types, codes and helper functions of the endpoint zero control transfer unit.
// No dependencies; every other file but the assertion macros header imports this package.
package ep0ctu_pkg;

    localparam int unsigned MAX_PACKET = 64;
    localparam int unsigned MIN_PACKET = 8;
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    // Fixed reply lengths of requests that need no configured length.
    localparam logic [9:0] LANGID_LEN      = 10'd4;
    localparam logic [9:0] STATUS_LEN      = 10'd2;
    localparam logic [9:0] CONFIG_BYTE_LEN = 10'd1;

    // Register reset values.
    localparam logic [6:0] RST_MAX_PACKET  = 7'd64;
    localparam logic [7:0] RST_DEVICE_LEN  = 8'd18;
    localparam logic [9:0] RST_CONFIG_LEN  = 10'd32;
    localparam logic [7:0] RST_STRING_LEN  = 8'd2;
    localparam int unsigned NUM_STRINGS    = 5;

    typedef enum logic [1:0] {
        MODE_SETUP    = 2'd0,
        MODE_IN_DONE  = 2'd1,
        MODE_OUT_DONE = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        SRC_NONE      = 4'd0,
        SRC_DEVICE    = 4'd1,
        SRC_CONFIG    = 4'd2,
        SRC_LANGID    = 4'd3,
        SRC_STR1      = 4'd4,
        SRC_STR2      = 4'd5,
        SRC_STR3      = 4'd6,
        SRC_STR4      = 4'd7,
        SRC_STR5      = 4'd8,
        SRC_CONF_BYTE = 4'd9,
        SRC_STATUS    = 4'd10
    } t_src;

    typedef enum logic [2:0] {
        REG_MAX_PACKET = 3'd0,
        REG_DEVICE_LEN = 3'd1,
        REG_CONFIG_LEN = 3'd2,
        REG_MFR_STR    = 3'd3,
        REG_PROD_STR   = 3'd4,
        REG_SERIAL_STR = 3'd5,
        REG_CONF_STR   = 3'd6,
        REG_IFACE_STR  = 3'd7
    } t_reg_idx;

    // Standard request codes.
    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
    localparam logic [7:0] REQ_ASSIGN_ADDR       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

    localparam logic [1:0] RTYPE_STANDARD = 2'd0;
    localparam logic [1:0] RTYPE_VENDOR   = 2'd2;
    localparam logic [4:0] RECIP_ENDPOINT = 5'd2;

    localparam logic [7:0] DT_DEVICE = 8'd1;
    localparam logic [7:0] DT_CONFIG = 8'd2;
    localparam logic [7:0] DT_STRING = 8'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] value_word;
        logic [15:0] index_word;
        logic [15:0] length_word;
    } t_evt;

    typedef struct packed {
        logic       stall_res;
        t_src       source_select;
        logic [9:0] source_offset;
        logic [6:0] tx_count;
        logic       tx_armed;
        logic       rx_armed;
        logic       data_toggle;
        logic       address_commit;
        logic [6:0] device_address;
        logic       configured;
    } t_res;

    typedef struct packed {
        logic [6:0]                       ep0_max_packet;
        logic [7:0]                       device_desc_len;
        logic [9:0]                       config_desc_len;
        logic [NUM_STRINGS-1:0][7:0]      str_len;
    } t_cfg;

    typedef struct packed {
        logic        status_stage;
        logic        multi_packet;
        logic [15:0] remaining_bytes;
        t_src        current_source;
        logic [9:0]  current_offset;
        logic [6:0]  pending_address;
        logic        enumerated;
    } t_state;

    typedef struct packed {
        logic        more;
        t_src        src;
        logic [9:0]  off;
        logic [6:0]  tx_count;
        logic [15:0] rem;
        t_src        next_src;
        logic [9:0]  next_off;
    } t_chunk;

    function automatic logic [6:0] clamp_mps(input logic [6:0] m);
        logic [6:0] r;
        r = m;
        if (m < 7'(MIN_PACKET)) begin
            r = 7'(MIN_PACKET);
        end else if (m > 7'(MAX_PACKET)) begin
            r = 7'(MAX_PACKET);
        end
        return r;
    endfunction

    // Cuts one IN packet from the pending transfer. A final chunk clears
    // the transfer; a zero-length final chunk reports no source.
    function automatic t_chunk send_chunk(input logic [15:0] rem, input t_src src,
                                          input logic [9:0] off, input logic [6:0] mps);
        t_chunk c;
        c = '0;
        c.next_src = SRC_NONE;
        c.src      = SRC_NONE;
        if (rem > {9'd0, mps}) begin
            c.more     = 1'b1;
            c.src      = src;
            c.off      = off;
            c.tx_count = mps;
            c.rem      = rem - {9'd0, mps};
            c.next_src = src;
            c.next_off = off + {3'd0, mps};
        end else if (rem != 16'd0) begin
            c.src      = src;
            c.off      = off;
            c.tx_count = rem[6:0];
        end
        return c;
    endfunction

endpackage

FILE: src/ep0ctu_evt_if.sv
// Event channel of the endpoint zero control transfer unit.
// Depends on ep0ctu_pkg for the item type.
interface ep0ctu_evt_if import ep0ctu_pkg::*; ();
    logic valid;
    logic ready;
    t_evt item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: src/ep0ctu_res_if.sv
// Result channel of the endpoint zero control transfer unit.
// Depends on ep0ctu_pkg for the item type.
interface ep0ctu_res_if import ep0ctu_pkg::*; ();
    logic valid;
    logic ready;
    t_res item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: src/usb_ep0_control_transfer_unit.sv
// Endpoint zero control transfer unit. Each event item (setup, IN done, OUT
// done) is captured in an input register, decoded combinationally against
// the transfer state and written to a result register together with the
// updated state once that register is free or drains. One item is taken
// every cycle as long as results are drained. While a finished result waits
// to be taken, the input register holds its item, so the input stalls once
// both registers are full. The APB registers should only be written while
// no event is in flight.
`include "usb_ep0_control_transfer_unit_macros.svh"

module usb_ep0_control_transfer_unit import ep0ctu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ep0ctu_evt_if.sink            i_evt,
    ep0ctu_res_if.source          o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg   cfg;
    logic   r_in_valid;
    t_evt   r_in_item;
    logic   r_out_valid;
    t_res   r_out_item;
    t_state r_state;
    t_state n_state;
    t_res   n_res;
    logic   advance;

    ep0ctu_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ep0ctu_step u_step (
        .i_evt   (r_in_item),
        .i_state (r_state),
        .i_cfg   (cfg),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // The held item is processed when the result register is free or drains now.
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_evt.ready = !r_in_valid || advance;
    assign o_res.valid = r_out_valid;
    assign o_res.item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_evt.ready) begin
                r_in_valid <= i_evt.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in_item <= i_evt.item;
        end
        if (advance) begin
            r_out_item <= n_res;
        end
    end

    `EP0_ASSERT_NOW(a_stall_not_armed, r_out_valid && r_out_item.stall_res,
        !r_out_item.tx_armed && !r_out_item.rx_armed, "stalled result arms an endpoint side")
    `EP0_ASSERT_NOW(a_commit_in_status, r_out_valid && r_out_item.address_commit,
        r_out_item.rx_armed && r_out_item.device_address != 7'd0,
        "address commit outside a valid status stage")
    `EP0_ASSERT_NOW(a_tx_count_bound, r_out_valid, r_out_item.tx_count <= 7'(MAX_PACKET),
        "IN packet larger than maximum packet size")
    `EP0_ASSERT_NOW(a_empty_has_no_source, r_state.remaining_bytes == 16'd0,
        r_state.current_source == SRC_NONE, "empty transfer still names a source")
    `EP0_ASSERT_NEXT(a_enumerated_sticks, r_state.enumerated, r_state.enumerated,
        "configured flag cleared without reset")

endmodule

FILE: src/ep0ctu_apb_regs.sv
// APB configuration registers: packet size and descriptor lengths.
// Depends on ep0ctu_pkg.
module ep0ctu_apb_regs import ep0ctu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ep0_max_packet  <= RST_MAX_PACKET;
            r_cfg.device_desc_len <= RST_DEVICE_LEN;
            r_cfg.config_desc_len <= RST_CONFIG_LEN;
            r_cfg.str_len         <= {NUM_STRINGS{RST_STRING_LEN}};
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MAX_PACKET: r_cfg.ep0_max_packet  <= pwdata[6:0];
                REG_DEVICE_LEN: r_cfg.device_desc_len <= pwdata[7:0];
                REG_CONFIG_LEN: r_cfg.config_desc_len <= pwdata[9:0];
                REG_MFR_STR:    r_cfg.str_len[0]      <= pwdata[7:0];
                REG_PROD_STR:   r_cfg.str_len[1]      <= pwdata[7:0];
                REG_SERIAL_STR: r_cfg.str_len[2]      <= pwdata[7:0];
                REG_CONF_STR:   r_cfg.str_len[3]      <= pwdata[7:0];
                REG_IFACE_STR:  r_cfg.str_len[4]      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_MAX_PACKET: prdata = CFG_DATA_W'(r_cfg.ep0_max_packet);
            REG_DEVICE_LEN: prdata = CFG_DATA_W'(r_cfg.device_desc_len);
            REG_CONFIG_LEN: prdata = CFG_DATA_W'(r_cfg.config_desc_len);
            REG_MFR_STR:    prdata = CFG_DATA_W'(r_cfg.str_len[0]);
            REG_PROD_STR:   prdata = CFG_DATA_W'(r_cfg.str_len[1]);
            REG_SERIAL_STR: prdata = CFG_DATA_W'(r_cfg.str_len[2]);
            REG_CONF_STR:   prdata = CFG_DATA_W'(r_cfg.str_len[3]);
            REG_IFACE_STR:  prdata = CFG_DATA_W'(r_cfg.str_len[4]);
            default: ;
        endcase
    end

endmodule

FILE: src/ep0ctu_step.sv
// Combinational request decode and transfer sequencing for one event.
// Depends on ep0ctu_pkg for types, codes and the chunk helper.
module ep0ctu_step import ep0ctu_pkg::*; (
    input  t_evt   i_evt,
    input  t_state i_state,
    input  t_cfg   i_cfg,
    output t_state o_state,
    output t_res   o_res
);

    logic [6:0] mps;
    logic [1:0] rtype;
    logic [4:0] recip;
    logic [7:0] dtype;
    logic [7:0] dix;
    logic [2:0] sidx;
    logic [9:0] len;
    logic [9:0] cut;
    t_src       src;
    logic       stall;
    logic       addr_req;
    logic       big;
    logic       ep_ok;
    t_chunk     ch;
    t_state     ns;
    t_res       res;

    always_comb begin
        mps      = clamp_mps(i_cfg.ep0_max_packet);
        rtype    = i_evt.request_type[6:5];
        recip    = i_evt.request_type[4:0];
        dtype    = i_evt.value_word[15:8];
        dix      = i_evt.value_word[7:0];
        sidx     = 3'(dix - 8'd1);
        // Endpoints one to three in either direction.
        ep_ok    = (i_evt.index_word[6:2] == 5'd0) && (i_evt.index_word[1:0] != 2'd0);
        big      = i_state.remaining_bytes > {9'd0, mps};
        len      = '0;
        cut      = '0;
        src      = SRC_NONE;
        stall    = 1'b0;
        addr_req = 1'b0;
        ch       = '0;
        ns       = i_state;
        res      = '0;

        unique case (t_mode'(i_evt.mode))
            MODE_SETUP: begin
                ns.status_stage    = 1'b0;
                ns.multi_packet    = 1'b0;
                ns.remaining_bytes = '0;
                ns.current_source  = SRC_NONE;
                ns.current_offset  = '0;
                if (rtype == RTYPE_STANDARD) begin
                    unique case (i_evt.request_code)
                        REQ_GET_DESCRIPTOR: begin
                            if (dtype == DT_DEVICE) begin
                                len = {2'd0, i_cfg.device_desc_len};
                                src = SRC_DEVICE;
                            end else if (dtype == DT_CONFIG) begin
                                len = i_cfg.config_desc_len;
                                src = SRC_CONFIG;
                            end else if (dtype == DT_STRING && dix == 8'd0) begin
                                len = LANGID_LEN;
                                src = SRC_LANGID;
                            end else if (dtype == DT_STRING && dix <= 8'(NUM_STRINGS)) begin
                                len = {2'd0, i_cfg.str_len[sidx]};
                                src = t_src'(4'(SRC_STR1) + {1'b0, sidx});
                            end else begin
                                stall = 1'b1;
                            end
                        end
                        REQ_ASSIGN_ADDR: begin
                            addr_req           = 1'b1;
                            ns.pending_address = i_evt.value_word[6:0];
                        end
                        REQ_GET_CONFIGURATION: begin
                            len = CONFIG_BYTE_LEN;
                            src = SRC_CONF_BYTE;
                        end
                        REQ_SET_CONFIGURATION: ns.enumerated = 1'b1;
                        REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                            stall = !(recip == RECIP_ENDPOINT && ep_ok);
                        end
                        REQ_GET_STATUS: begin
                            len = STATUS_LEN;
                            src = SRC_STATUS;
                        end
                        default: ;
                    endcase
                end else if (rtype != RTYPE_VENDOR) begin
                    stall = 1'b1;
                end

                if (stall) begin
                    res.stall_res = 1'b1;
                end else begin
                    cut = ({6'd0, len} > i_evt.length_word) ? i_evt.length_word[9:0] : len;
                    ns.remaining_bytes = {6'd0, cut};
                    ns.current_source  = (cut != 10'd0) ? src : SRC_NONE;
                    res.tx_armed       = 1'b1;
                    res.data_toggle    = 1'b1;
                    // An address request goes straight to its status stage.
                    if (addr_req) begin
                        ns.status_stage = 1'b1;
                    end else begin
                        ch = send_chunk(ns.remaining_bytes, ns.current_source, 10'd0, mps);
                        res.source_select  = ch.src;
                        res.source_offset  = ch.off;
                        res.tx_count       = ch.tx_count;
                        ns.remaining_bytes = ch.rem;
                        ns.current_source  = ch.next_src;
                        ns.current_offset  = ch.next_off;
                        ns.multi_packet    = ch.more;
                    end
                end
            end
            MODE_IN_DONE: begin
                if (!i_state.status_stage) begin
                    if (big || i_state.multi_packet) begin
                        ch = send_chunk(i_state.remaining_bytes, i_state.current_source,
                                        i_state.current_offset, mps);
                        res.source_select  = ch.src;
                        res.source_offset  = ch.off;
                        res.tx_count       = ch.tx_count;
                        res.tx_armed       = 1'b1;
                        ns.remaining_bytes = ch.rem;
                        ns.current_source  = ch.next_src;
                        ns.current_offset  = ch.next_off;
                        if (!big) begin
                            ns.multi_packet = 1'b0;
                        end
                    end else begin
                        ns.remaining_bytes = '0;
                        ns.current_source  = SRC_NONE;
                        ns.current_offset  = '0;
                        ns.status_stage    = 1'b1;
                        res.rx_armed       = 1'b1;
                        res.data_toggle    = 1'b1;
                    end
                end else begin
                    ns.status_stage = 1'b0;
                    ns.multi_packet = 1'b0;
                    res.rx_armed    = 1'b1;
                    if (i_state.pending_address != 7'd0 && i_state.remaining_bytes == 16'd0) begin
                        res.address_commit = 1'b1;
                        res.device_address = i_state.pending_address;
                        ns.pending_address = '0;
                    end
                end
            end
            MODE_OUT_DONE: begin
                if (!i_state.status_stage) begin
                    ns.status_stage = 1'b1;
                    res.tx_armed    = 1'b1;
                    res.data_toggle = 1'b1;
                end else begin
                    ns.status_stage = 1'b0;
                    ns.multi_packet = 1'b0;
                    res.rx_armed    = 1'b1;
                end
            end
            default: ;
        endcase

        res.configured = ns.enumerated;
        o_state        = ns;
        o_res          = res;
    end

endmodule

FILE: test/usb_ep0_control_transfer_unit_test.sv
// Self-checking testbench of the endpoint zero control transfer unit.
// It drives event items and APB register writes, predicts each result item and checks it.
// Depends on ep0ctu_pkg, ep0ctu_evt_if, ep0ctu_res_if and usb_ep0_control_transfer_unit.
module usb_ep0_control_transfer_unit_test import ep0ctu_pkg::*; ();

    localparam int CYCLE_LIMIT = 400000;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [7:0] RT_STD_DEV_OUT   = 8'h00;
    localparam logic [7:0] RT_STD_IFACE_OUT = 8'h01;
    localparam logic [7:0] RT_STD_EP_OUT    = 8'h02;
    localparam logic [7:0] RT_STD_DEV_IN    = 8'h80;
    localparam logic [7:0] RT_CLASS_IFACE   = 8'h21;
    localparam logic [7:0] RT_RESERVED      = 8'h60;
    localparam logic [7:0] RT_VENDOR_IN     = 8'hC0;
    localparam logic [7:0] DT_QUALIFIER     = 8'h06;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    ep0ctu_evt_if evt_ch ();
    ep0ctu_res_if res_ch ();

    usb_ep0_control_transfer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted transfer state and the register values the block should hold.
    logic        in_status;
    logic        status_out;
    logic        more_chunks;
    logic [15:0] bytes_left;
    t_src        cur_src;
    logic [9:0]  cur_off;
    logic [6:0]  addr_pending;
    logic        dev_configured;
    logic [31:0] reg_mirror [8];

    t_res expected_res_q [$];
    t_res last_pred;
    int   items_sent = 0;
    int   err_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_len = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("usb_ep0_control_transfer_unit_test: errors");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever the test asks for one.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            err_count = err_count + 1;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_res want;
        t_res got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.item;
            if (expected_res_q.size() == 0) begin
                $display("%0t: result item with nothing expected: actual %h", $time, got);
                err_count = err_count + 1;
            end else begin
                want = expected_res_q.pop_front();
                check_field("stall_res", 32'(want.stall_res), 32'(got.stall_res));
                check_field("source_select", 32'(want.source_select),
                            32'(got.source_select));
                check_field("source_offset", 32'(want.source_offset),
                            32'(got.source_offset));
                check_field("tx_count", 32'(want.tx_count), 32'(got.tx_count));
                check_field("tx_armed", 32'(want.tx_armed), 32'(got.tx_armed));
                check_field("rx_armed", 32'(want.rx_armed), 32'(got.rx_armed));
                check_field("data_toggle", 32'(want.data_toggle), 32'(got.data_toggle));
                check_field("address_commit", 32'(want.address_commit),
                            32'(got.address_commit));
                check_field("device_address", 32'(want.device_address),
                            32'(got.device_address));
                check_field("configured", 32'(want.configured), 32'(got.configured));
            end
        end
    end

    function automatic logic [6:0] packet_limit();
        logic [6:0] m;
        m = reg_mirror[REG_MAX_PACKET][6:0];
        if (m < 7'(MIN_PACKET)) begin
            m = 7'(MIN_PACKET);
        end else if (m > 7'(MAX_PACKET)) begin
            m = 7'(MAX_PACKET);
        end
        return m;
    endfunction

    // Arms the next IN chunk; returns 1 when bytes are still left after it.
    function automatic bit next_chunk(inout t_res r);
        logic [6:0] m;
        m = packet_limit();
        if (bytes_left > 16'(m)) begin
            r.source_select = cur_src;
            r.source_offset = cur_off;
            r.tx_count      = m;
            bytes_left      = bytes_left - 16'(m);
            cur_off         = cur_off + 10'(m);
            return 1'b1;
        end
        if (bytes_left != 16'd0) begin
            r.source_select = cur_src;
            r.source_offset = cur_off;
            r.tx_count      = bytes_left[6:0];
        end
        bytes_left = 16'd0;
        cur_src    = SRC_NONE;
        cur_off    = 10'd0;
        return 1'b0;
    endfunction

    function automatic void decode_setup(input t_evt e, inout t_res r);
        logic [1:0]  rtype;
        logic [4:0]  recip;
        logic [7:0]  dtype;
        logic [7:0]  dix;
        logic [15:0] len;
        t_src        src;
        bit          stall;
        rtype = e.request_type[6:5];
        recip = e.request_type[4:0];
        dtype = e.value_word[15:8];
        dix   = e.value_word[7:0];
        len   = 16'd0;
        src   = SRC_NONE;
        stall = 1'b0;
        in_status   = 1'b0;
        status_out  = 1'b0;
        more_chunks = 1'b0;
        bytes_left  = 16'd0;
        cur_src     = SRC_NONE;
        cur_off     = 10'd0;
        if (rtype == RTYPE_STANDARD) begin
            case (e.request_code)
                REQ_GET_DESCRIPTOR: begin
                    if (dtype == DT_DEVICE) begin
                        len = 16'(reg_mirror[REG_DEVICE_LEN][7:0]);
                        src = SRC_DEVICE;
                    end else if (dtype == DT_CONFIG) begin
                        len = 16'(reg_mirror[REG_CONFIG_LEN][9:0]);
                        src = SRC_CONFIG;
                    end else if (dtype == DT_STRING && dix == 8'd0) begin
                        len = 16'(LANGID_LEN);
                        src = SRC_LANGID;
                    end else if (dtype == DT_STRING && dix <= 8'(NUM_STRINGS)) begin
                        len = 16'(reg_mirror[REG_MFR_STR + dix - 1][7:0]);
                        src = t_src'(SRC_LANGID + dix[3:0]);
                    end else begin
                        stall = 1'b1;
                    end
                end
                REQ_ASSIGN_ADDR: begin
                    in_status    = 1'b1;
                    addr_pending = e.value_word[6:0];
                end
                REQ_GET_CONFIGURATION: begin
                    len = 16'(CONFIG_BYTE_LEN);
                    src = SRC_CONF_BYTE;
                end
                REQ_SET_CONFIGURATION: begin
                    dev_configured = 1'b1;
                end
                REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                    // Only features of endpoints 1 to 3, either direction, are taken.
                    if (recip != RECIP_ENDPOINT || e.index_word[6:0] < 7'd1 ||
                        e.index_word[6:0] > 7'd3) begin
                        stall = 1'b1;
                    end
                end
                REQ_GET_STATUS: begin
                    len = 16'(STATUS_LEN);
                    src = SRC_STATUS;
                end
                default: begin
                end
            endcase
        end else if (rtype != RTYPE_VENDOR) begin
            stall = 1'b1;
        end
        if (stall) begin
            r.stall_res = 1'b1;
            return;
        end
        if (len > e.length_word) begin
            len = e.length_word;
        end
        bytes_left = len;
        cur_src    = (len != 16'd0) ? src : SRC_NONE;
        // A setup always starts in the IN direction.
        if (!in_status && next_chunk(r)) begin
            more_chunks = 1'b1;
        end
        r.tx_armed    = 1'b1;
        r.data_toggle = 1'b1;
    endfunction

    function automatic void finish_in_event(inout t_res r);
        if (!in_status) begin
            if (bytes_left > 16'(packet_limit())) begin
                void'(next_chunk(r));
                r.tx_armed = 1'b1;
            end else if (more_chunks) begin
                more_chunks = 1'b0;
                void'(next_chunk(r));
                r.tx_armed = 1'b1;
            end else begin
                bytes_left    = 16'd0;
                cur_src       = SRC_NONE;
                cur_off       = 10'd0;
                in_status     = 1'b1;
                status_out    = 1'b1;
                r.rx_armed    = 1'b1;
                r.data_toggle = 1'b1;
            end
        end else begin
            in_status   = 1'b0;
            status_out  = 1'b0;
            more_chunks = 1'b0;
            r.rx_armed  = 1'b1;
            if (addr_pending != 7'd0 && bytes_left == 16'd0) begin
                r.address_commit = 1'b1;
                r.device_address = addr_pending;
                addr_pending     = 7'd0;
            end
        end
    endfunction

    function automatic void finish_out_event(inout t_res r);
        if (!in_status) begin
            in_status     = 1'b1;
            r.tx_armed    = 1'b1;
            r.data_toggle = 1'b1;
        end else begin
            in_status   = 1'b0;
            status_out  = 1'b0;
            more_chunks = 1'b0;
            r.rx_armed  = 1'b1;
        end
    endfunction

    function automatic t_res predict_result(input t_evt e);
        t_res r;
        r = '0;
        case (e.mode)
            MODE_SETUP:    decode_setup(e, r);
            MODE_IN_DONE:  finish_in_event(r);
            MODE_OUT_DONE: finish_out_event(r);
            default: begin
            end
        endcase
        r.configured = dev_configured;
        return r;
    endfunction

    task automatic send_evt(input t_evt e);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            evt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.item  <= e;
        do @(posedge i_clk); while (!evt_ch.ready);
        last_pred = predict_result(e);
        expected_res_q.push_back(last_pred);
        items_sent = items_sent + 1;
    endtask

    task automatic drain_results();
        evt_ch.valid <= 1'b0;
        while (expected_res_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input t_reg_idx idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_registers();
        logic [31:0] got;
        for (int i = 0; i < 8; i++) begin
            apb_read(t_reg_idx'(i), got);
            if (got !== reg_mirror[i]) begin
                $display("%0t: register %0d read back: expected %0h, actual %0h",
                         $time, i, reg_mirror[i], got);
                err_count = err_count + 1;
            end
        end
    endtask

    // The caller makes sure no item is in flight.
    task automatic load_config(input t_cfg c);
        logic [31:0] val [8];
        logic [31:0] data;
        int          w;
        val[REG_MAX_PACKET] = 32'(c.ep0_max_packet);
        val[REG_DEVICE_LEN] = 32'(c.device_desc_len);
        val[REG_CONFIG_LEN] = 32'(c.config_desc_len);
        for (int k = 0; k < NUM_STRINGS; k++) begin
            val[REG_MFR_STR + k] = 32'(c.str_len[k]);
        end
        for (int i = 0; i < 8; i++) begin
            w = (i == REG_MAX_PACKET) ? 7 : (i == REG_CONFIG_LEN) ? 10 : 8;
            data = val[i];
            // Bits above the register width must be dropped by the block.
            if ($urandom_range(0, 1) == 1) begin
                data = data | ($urandom & ~((32'd1 << w) - 32'd1));
            end
            apb_write(t_reg_idx'(i), data);
            reg_mirror[i] = val[i];
        end
        check_registers();
    endtask

    function automatic t_evt mk_setup(input logic [7:0] rt, input logic [7:0] code,
                                      input logic [15:0] val, input logic [15:0] idx,
                                      input logic [15:0] len);
        t_evt e;
        e.mode         = MODE_SETUP;
        e.request_type = rt;
        e.request_code = code;
        e.value_word   = val;
        e.index_word   = idx;
        e.length_word  = len;
        return e;
    endfunction

    // Setup fields of a non-setup event carry junk that the block must ignore.
    function automatic t_evt mk_event(input logic [1:0] mode);
        t_evt e;
        e = mk_setup(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        e.mode = mode;
        return e;
    endfunction

    function automatic t_evt random_noise();
        return mk_event(2'($urandom_range(0, 3)));
    endfunction

    function automatic logic [15:0] random_length();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1, 2:    return 16'hFFFF;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 80));
        endcase
    endfunction

    function automatic t_evt random_setup();
        t_evt       e;
        logic [7:0] dt;
        logic [7:0] dx;
        e = mk_setup({1'($urandom_range(0, 1)), RTYPE_STANDARD, 5'd0}, REQ_GET_STATUS,
                     16'($urandom), 16'($urandom), random_length());
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: begin
                case ($urandom_range(0, 7))
                    0, 1:    dt = DT_DEVICE;
                    2, 3:    dt = DT_CONFIG;
                    4, 5, 6: dt = DT_STRING;
                    default: dt = 8'($urandom);
                endcase
                dx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
                e.request_code = REQ_GET_DESCRIPTOR;
                e.value_word   = {dt, dx};
            end
            8:      e.request_code = REQ_GET_STATUS;
            9:      e.request_code = REQ_GET_CONFIGURATION;
            10, 11: e.request_code = REQ_SET_CONFIGURATION;
            12, 13: e.request_code = REQ_ASSIGN_ADDR;
            14, 15: begin
                e.request_code = ($urandom_range(0, 1) == 1) ? REQ_SET_FEATURE
                                                              : REQ_CLEAR_FEATURE;
                e.request_type[4:0] = RECIP_ENDPOINT;
                if ($urandom_range(0, 2) != 0) begin
                    e.index_word[7:0] = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 4))};
                end
            end
            16: begin
                e.request_code = ($urandom_range(0, 1) == 1) ? REQ_SET_FEATURE
                                                              : REQ_CLEAR_FEATURE;
                e.request_type[4:0] = 5'($urandom);
            end
            17: begin
                e.request_type = {1'($urandom_range(0, 1)), RTYPE_VENDOR, 5'($urandom)};
                e.request_code = 8'($urandom);
            end
            18: begin
                e.request_type = 8'($urandom);
                e.request_code = 8'($urandom);
            end
            default: e.request_code = 8'($urandom);
        endcase
        return e;
    endfunction

    // One control transfer as a host runs it: setup, IN data chunks, then the status stage.
    task automatic run_transfer();
        int steps;
        send_evt(random_setup());
        steps = 0;
        while (!last_pred.stall_res && steps < 160) begin
            if ($urandom_range(0, 39) == 0) begin
                // A broken transfer: a stray event, or just the next setup.
                if ($urandom_range(0, 1) == 1) begin
                    send_evt(random_noise());
                end
                break;
            end
            if (in_status) begin
                send_evt(mk_event(status_out ? MODE_OUT_DONE : MODE_IN_DONE));
                break;
            end
            send_evt(mk_event(MODE_IN_DONE));
            steps = steps + 1;
        end
    endtask

    task automatic test_directed_requests();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_evt(mk_setup(RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'h0000,
                          16'hFFFF));
        send_evt(mk_event(MODE_IN_DONE));
        send_evt(mk_event(MODE_OUT_DONE));
        // Reply cut to the host's length, then dropped by the next setup.
        send_evt(mk_setup(RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'hFF}, 16'hFFFF,
                          16'd9));
        send_evt(mk_setup(RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'd0}, 16'h0409,
                          16'hFFFF));
        send_evt(mk_setup(RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'd5}, 16'h0000,
                          16'hFFFF));
        send_evt(mk_setup(RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'd6}, 16'h0000,
                          16'hFFFF));
        send_evt(mk_setup(RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, {DT_QUALIFIER, 8'd0}, 16'h0000,
                          16'd10));
        send_evt(mk_setup(RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, 16'hFF00, 16'h0000, 16'd64));
        send_evt(mk_setup(RT_VENDOR_IN, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_evt(mk_setup(RT_CLASS_IFACE, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'h0000,
                          16'd18));
        send_evt(mk_setup(RT_RESERVED, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'd2));
        send_evt(mk_setup(RT_STD_DEV_OUT, REQ_SET_FEATURE, 16'd1, 16'h0000, 16'd0));
        send_evt(mk_setup(RT_STD_EP_OUT, REQ_CLEAR_FEATURE, 16'd0, 16'hFF81, 16'd0));
        send_evt(mk_setup(RT_STD_EP_OUT, REQ_SET_FEATURE, 16'd0, 16'h0084, 16'd0));
        send_evt(mk_setup(RT_STD_EP_OUT, REQ_SET_FEATURE, 16'd0, 16'h0000, 16'd0));
        send_evt(mk_setup(RT_STD_IFACE_OUT, REQ_CLEAR_FEATURE, 16'd0, 16'h0001, 16'd0));
        send_evt(mk_setup(RT_STD_DEV_IN, REQ_GET_STATUS, 16'd0, 16'd0, 16'hFFFF));
        send_evt(mk_setup(RT_STD_DEV_IN, REQ_GET_CONFIGURATION, 16'd0, 16'd0, 16'hFFFF));
        send_evt(mk_setup(RT_STD_DEV_OUT, REQ_SET_CONFIGURATION, 16'hFFFF, 16'd0, 16'd0));
        // The address is committed once the IN status stage completes.
        send_evt(mk_setup(RT_STD_DEV_OUT, REQ_ASSIGN_ADDR, 16'hFFFF, 16'd0, 16'd0));
        send_evt(mk_event(MODE_IN_DONE));
        send_evt(mk_event(MODE_OUT_DONE));
        send_evt(mk_setup(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF) | t_evt'({MODE_UNUSED,
                          64'd0}));
        send_evt(mk_setup(RT_STD_DEV_OUT, REQ_GET_STATUS, 16'd0, 16'd0, 16'd0));
        drain_results();
    endtask

    task automatic test_register_access();
        check_registers();
        load_config('0);
        load_config('1);
        load_config({RST_MAX_PACKET, RST_DEVICE_LEN, RST_CONFIG_LEN, {5{RST_STRING_LEN}}});
    endtask

    task automatic test_backpressure();
        int target;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len = 300;
        hold_req = hold_req + 1;
        target = items_sent + 40;
        while (items_sent < target) begin
            run_transfer();
        end
        drain_results();
    endtask

    task automatic test_random_transfers();
        int   target;
        int   pick;
        t_cfg c;
        for (int p = 0; p < 8; p++) begin
            drain_results();
            case (p)
                0: c = '0;
                1: c = {7'h7F, 8'hFF, 10'h3FF, {5{8'hFF}}};
                2: c = {7'd8, 8'hFF, 10'h3FF, {5{8'hFF}}};
                3: c = {7'd64, RST_DEVICE_LEN, 10'h3FF, {5{RST_STRING_LEN}}};
                default: begin
                    c.ep0_max_packet  = 7'($urandom_range(0, 127));
                    c.device_desc_len = 8'($urandom);
                    c.config_desc_len = ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                                     : 10'($urandom_range(0, 200));
                    for (int k = 0; k < NUM_STRINGS; k++) begin
                        c.str_len[k] = 8'($urandom);
                    end
                end
            endcase
            load_config(c);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            target = items_sent + 190;
            while (items_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    run_transfer();
                end else if (pick < 98) begin
                    send_evt(random_noise());
                end else begin
                    drain_results();
                end
            end
        end
        drain_results();
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        evt_ch.valid = 1'b0;
        evt_ch.item  = '0;
        in_status      = 1'b0;
        status_out     = 1'b0;
        more_chunks    = 1'b0;
        bytes_left     = 16'd0;
        cur_src        = SRC_NONE;
        cur_off        = 10'd0;
        addr_pending   = 7'd0;
        dev_configured = 1'b0;
        last_pred      = '0;
        reg_mirror[REG_MAX_PACKET] = 32'(RST_MAX_PACKET);
        reg_mirror[REG_DEVICE_LEN] = 32'(RST_DEVICE_LEN);
        reg_mirror[REG_CONFIG_LEN] = 32'(RST_CONFIG_LEN);
        for (int k = 0; k < NUM_STRINGS; k++) begin
            reg_mirror[REG_MFR_STR + k] = 32'(RST_STRING_LEN);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_requests();
        test_register_access();
        test_backpressure();
        test_random_transfers();
        if (err_count == 0) begin
            $display("usb_ep0_control_transfer_unit_test: clean");
        end else begin
            $display("usb_ep0_control_transfer_unit_test: errors");
        end
        $finish;
    end

endmodule
